// ===== rtl/assert_macros.svh =====
// assert_macros.svh: assertion macros used by the checker file.
// Depends on nothing; users supply clk and rst in their own scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold on every clock edge outside reset.
`define CHK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// If the antecedent holds, the consequent must hold in the next cycle.
`define CHK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/wsfr_pkg.sv =====
// wsfr_pkg: types, codes and helpers of the websocket frame receiver.
// Used by websocket_frame_receiver; depends on nothing.
package wsfr_pkg;

  localparam int LenW   = 21;
  localparam int HdrW   = 4;
  localparam int CountW = 4;

  localparam logic [LenW-1:0] FragLimitReset = 21'd16384;
  localparam logic [LenW-1:0] MaxFrameReset  = 21'd65536;
  localparam logic [LenW-1:0] LenSat         = '1;

  // header parse phases
  typedef enum logic [5:0] {
    PH_HDR0  = 6'b000001,
    PH_HDR1  = 6'b000010,
    PH_EXT16 = 6'b000100,
    PH_EXT64 = 6'b001000,
    PH_MASK  = 6'b010000,
    PH_DATA  = 6'b100000
  } phase_t;

  // result kinds
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_PING  = 2'd1;
  localparam logic [1:0] KIND_CLOSE = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  // error codes
  localparam logic [1:0] ERR_RSV1      = 2'd0;
  localparam logic [1:0] ERR_RSV23     = 2'd1;
  localparam logic [1:0] ERR_FRAG_LIM  = 2'd2;
  localparam logic [1:0] ERR_TOO_LARGE = 2'd3;

  // opcodes
  localparam logic [3:0] OP_TEXT    = 4'h1;
  localparam logic [3:0] OP_BINARY  = 4'h2;
  localparam logic [3:0] OP_CONTROL = 4'h8;
  localparam logic [3:0] OP_CLOSE   = 4'h8;
  localparam logic [3:0] OP_PING    = 4'h9;

  // 7-bit length escapes
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // header sizes in bytes
  localparam logic [HdrW-1:0] HDR_BASE  = 4'd2;
  localparam logic [HdrW-1:0] HDR_EXT16 = 4'd4;
  localparam logic [HdrW-1:0] HDR_EXT64 = 4'd10;
  localparam logic [HdrW-1:0] HDR_KEY   = 4'd4;

  localparam logic [CountW-1:0] CNT_EXT16 = 4'd2;
  localparam logic [CountW-1:0] CNT_EXT64 = 4'd8;
  localparam logic [CountW-1:0] CNT_KEY   = 4'd4;

  typedef struct packed {
    logic [1:0] kind;
    logic       has_byte;
    logic [7:0] payload_byte;
    logic       is_binary;
    logic       last;
    logic [1:0] error_code;
  } res_t;

  function automatic res_t mk_res(input logic [1:0] kind, input logic has,
                                  input logic [7:0] data, input logic bin,
                                  input logic last, input logic [1:0] err);
    res_t r;
    r.kind         = kind;
    r.has_byte     = has;
    r.payload_byte = data;
    r.is_binary    = bin;
    r.last         = last;
    r.error_code   = err;
    return r;
  endfunction

endpackage

// ===== rtl/websocket_frame_receiver.sv =====
// websocket_frame_receiver: receive-side websocket deframer, one byte per word.
// Depends on wsfr_pkg.
// Result words pass through a registered queue and leave it in order.
// Throughput: one byte per cycle while in_ready is high; a byte can cause two
// result words, and in_ready drops while the 4-entry result queue has under 2 free.
// Reset (rst, synchronous): parser to first header byte, queue empty, registers defaults.
module websocket_frame_receiver (
  input  logic                     clk,
  input  logic                     rst,
  // byte input
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [7:0]               rx_byte,
  // result output
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               kind,
  output logic                     has_byte,
  output logic [7:0]               payload_byte,
  output logic                     is_binary,
  output logic                     last,
  output logic [1:0]               error_code,
  // configuration writes
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [wsfr_pkg::LenW-1:0] cfg_data
);

  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = QPtrW + 1;

  // configuration
  logic [wsfr_pkg::LenW-1:0] fragment_limit;
  logic [wsfr_pkg::LenW-1:0] max_frame_bytes;

  // parser state
  wsfr_pkg::phase_t            phase, phase_next;
  logic                        fin_flag, fin_flag_next;
  logic [3:0]                  frame_op, frame_op_next;
  logic                        mask_on, mask_on_next;
  logic [wsfr_pkg::CountW-1:0] field_cnt, field_cnt_next;
  // frame length: low 21 bits plus a flag for anything above them; any
  // frame beyond 21 bits fails the size check so the upper bits never matter
  logic [wsfr_pkg::LenW-1:0]   len_lo, len_lo_next;
  logic                        len_big, len_big_next;
  logic [wsfr_pkg::LenW-1:0]   pay_pos, pay_pos_next;
  logic [31:0]                 mask_word, mask_word_next;
  logic                        frag_active, frag_active_next;
  logic [3:0]                  frag_op, frag_op_next;
  logic [wsfr_pkg::LenW-1:0]   frag_total, frag_total_next;
  logic                        dead, dead_next;

  // per-byte results
  wsfr_pkg::res_t step_res [2];
  logic [1:0]     step_cnt;

  // result queue
  wsfr_pkg::res_t     q_mem [QDepth];
  logic [QPtrW-1:0]   q_wp, q_rp;
  logic [QCntW-1:0]   q_cnt, q_cnt_next;

  logic in_fire, out_fire;

  assign in_ready = (q_cnt <= QCntW'(QDepth - 2));
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // ------------------------------------------------------------------
  // Byte decode: all header/payload work for one byte, single pass.
  // ------------------------------------------------------------------
  always_comb begin
    logic                        do_len;
    logic                        do_begin;
    logic                        do_fin;
    logic                        empty;
    logic [wsfr_pkg::HdrW-1:0]   hdr_len;
    logic [wsfr_pkg::LenW:0]     need;
    logic [7:0]                  ub;
    logic [3:0]                  msg_op;
    logic                        frag_path;
    logic                        msg_ok;
    logic                        end_f;

    phase_next       = phase;
    fin_flag_next    = fin_flag;
    frame_op_next    = frame_op;
    mask_on_next     = mask_on;
    field_cnt_next   = field_cnt;
    len_lo_next      = len_lo;
    len_big_next     = len_big;
    pay_pos_next     = pay_pos;
    mask_word_next   = mask_word;
    frag_active_next = frag_active;
    frag_op_next     = frag_op;
    frag_total_next  = frag_total;
    dead_next        = dead;
    step_res[0]      = '0;
    step_res[1]      = '0;
    step_cnt         = '0;

    do_len   = 1'b0;
    do_begin = 1'b0;
    do_fin   = 1'b0;
    empty    = 1'b0;
    hdr_len  = wsfr_pkg::HDR_BASE;
    need     = '0;
    ub       = rx_byte;
    end_f    = 1'b0;

    msg_op    = frag_active ? frag_op : frame_op;
    frag_path = (frame_op < wsfr_pkg::OP_CONTROL) && (frag_active || !fin_flag);
    msg_ok    = (msg_op == wsfr_pkg::OP_TEXT) || (msg_op == wsfr_pkg::OP_BINARY);

    if (in_fire && !dead) begin
      unique case (phase)
        wsfr_pkg::PH_HDR0: begin
          if (rx_byte[6]) begin
            dead_next = 1'b1;
            step_res[step_cnt[0]] = wsfr_pkg::mk_res(wsfr_pkg::KIND_ERROR, 1'b0, 8'd0,
                                                     1'b0, 1'b0, wsfr_pkg::ERR_RSV1);
            step_cnt = step_cnt + 2'd1;
          end else if (rx_byte[5:4] != 2'b00) begin
            dead_next = 1'b1;
            step_res[step_cnt[0]] = wsfr_pkg::mk_res(wsfr_pkg::KIND_ERROR, 1'b0, 8'd0,
                                                     1'b0, 1'b0, wsfr_pkg::ERR_RSV23);
            step_cnt = step_cnt + 2'd1;
          end else begin
            fin_flag_next = rx_byte[7];
            frame_op_next = rx_byte[3:0];
            phase_next    = wsfr_pkg::PH_HDR1;
          end
        end
        wsfr_pkg::PH_HDR1: begin
          mask_on_next   = rx_byte[7];
          mask_word_next = '0;
          pay_pos_next   = '0;
          field_cnt_next = '0;
          len_lo_next    = '0;
          len_big_next   = 1'b0;
          if (rx_byte[6:0] == wsfr_pkg::LEN_EXT16) begin
            phase_next = wsfr_pkg::PH_EXT16;
          end else if (rx_byte[6:0] == wsfr_pkg::LEN_EXT64) begin
            phase_next = wsfr_pkg::PH_EXT64;
          end else begin
            len_lo_next = wsfr_pkg::LenW'(rx_byte[6:0]);
            do_len      = 1'b1;
          end
        end
        wsfr_pkg::PH_EXT16,
        wsfr_pkg::PH_EXT64: begin
          len_big_next   = len_big || (len_lo[wsfr_pkg::LenW-1 -: 8] != 8'd0);
          len_lo_next    = {len_lo[wsfr_pkg::LenW-9:0], rx_byte};
          field_cnt_next = field_cnt + wsfr_pkg::CountW'(1);
          hdr_len        = (phase == wsfr_pkg::PH_EXT16) ? wsfr_pkg::HDR_EXT16
                                                         : wsfr_pkg::HDR_EXT64;
          if (field_cnt_next == ((phase == wsfr_pkg::PH_EXT16) ? wsfr_pkg::CNT_EXT16
                                                                : wsfr_pkg::CNT_EXT64)) begin
            do_len = 1'b1;
          end
        end
        wsfr_pkg::PH_MASK: begin
          mask_word_next = {mask_word[23:0], rx_byte};
          field_cnt_next = field_cnt + wsfr_pkg::CountW'(1);
          if (field_cnt_next >= wsfr_pkg::CNT_KEY) begin
            do_begin = 1'b1;
          end
        end
        wsfr_pkg::PH_DATA: begin
          if (mask_on) begin
            ub = rx_byte ^ 8'(mask_word >> {~pay_pos[1:0], 3'b000});
          end
          pay_pos_next = pay_pos + wsfr_pkg::LenW'(1);
          end_f        = (pay_pos_next >= len_lo);
          if (frame_op == wsfr_pkg::OP_PING) begin
            step_res[step_cnt[0]] = wsfr_pkg::mk_res(wsfr_pkg::KIND_PING, 1'b1, ub,
                                                     1'b0, end_f, 2'd0);
            step_cnt = step_cnt + 2'd1;
          end else if (frame_op < wsfr_pkg::OP_CONTROL) begin
            if (frag_path && (frag_total != wsfr_pkg::LenSat)) begin
              frag_total_next = frag_total + wsfr_pkg::LenW'(1);
            end
            if (msg_ok) begin
              step_res[step_cnt[0]] = wsfr_pkg::mk_res(wsfr_pkg::KIND_DATA, 1'b1, ub,
                                                       msg_op == wsfr_pkg::OP_BINARY,
                                                       end_f && fin_flag, 2'd0);
              step_cnt = step_cnt + 2'd1;
            end
          end
          do_fin = end_f;
        end
        default: begin
          phase_next = wsfr_pkg::PH_HDR0;
        end
      endcase

      // length known: size check, then key or payload
      if (do_len) begin
        if (mask_on_next) begin
          hdr_len = hdr_len + wsfr_pkg::HDR_KEY;
        end
        need = (wsfr_pkg::LenW+1)'(len_lo_next) + (wsfr_pkg::LenW+1)'(hdr_len);
        if (len_big_next || (need > {1'b0, max_frame_bytes})) begin
          dead_next  = 1'b1;
          phase_next = wsfr_pkg::PH_HDR0;
          step_res[step_cnt[0]] = wsfr_pkg::mk_res(wsfr_pkg::KIND_ERROR, 1'b0, 8'd0,
                                                   1'b0, 1'b0, wsfr_pkg::ERR_TOO_LARGE);
          step_cnt = step_cnt + 2'd1;
        end else begin
          field_cnt_next = '0;
          if (mask_on_next) begin
            phase_next = wsfr_pkg::PH_MASK;
          end else begin
            do_begin = 1'b1;
          end
        end
      end

      // payload start; an empty frame finishes at once
      if (do_begin) begin
        pay_pos_next = '0;
        if (len_lo_next == '0) begin
          do_fin = 1'b1;
          empty  = 1'b1;
        end else begin
          phase_next = wsfr_pkg::PH_DATA;
        end
      end

      // frame end
      if (do_fin) begin
        phase_next = wsfr_pkg::PH_HDR0;
        if (frame_op == wsfr_pkg::OP_CLOSE) begin
          dead_next = 1'b1;
          step_res[step_cnt[0]] = wsfr_pkg::mk_res(wsfr_pkg::KIND_CLOSE, 1'b0, 8'd0,
                                                   1'b0, 1'b0, 2'd0);
          step_cnt = step_cnt + 2'd1;
        end else if (frame_op == wsfr_pkg::OP_PING) begin
          if (empty) begin
            step_res[step_cnt[0]] = wsfr_pkg::mk_res(wsfr_pkg::KIND_PING, 1'b0, 8'd0,
                                                     1'b0, 1'b1, 2'd0);
            step_cnt = step_cnt + 2'd1;
          end
        end else if (frame_op < wsfr_pkg::OP_CONTROL) begin
          if (fin_flag && empty && msg_ok) begin
            step_res[step_cnt[0]] = wsfr_pkg::mk_res(wsfr_pkg::KIND_DATA, 1'b0, 8'd0,
                                                     msg_op == wsfr_pkg::OP_BINARY,
                                                     1'b1, 2'd0);
            step_cnt = step_cnt + 2'd1;
          end
          if (frag_path) begin
            if (fin_flag) begin
              frag_active_next = 1'b0;
              frag_total_next  = '0;
            end else begin
              if (!frag_active) begin
                frag_active_next = 1'b1;
                frag_op_next     = frame_op;
              end
              if (frag_total_next >= fragment_limit) begin
                dead_next = 1'b1;
                step_res[step_cnt[0]] = wsfr_pkg::mk_res(wsfr_pkg::KIND_ERROR, 1'b0, 8'd0,
                                                         1'b0, 1'b0,
                                                         wsfr_pkg::ERR_FRAG_LIM);
                step_cnt = step_cnt + 2'd1;
              end
            end
          end
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // Parser and configuration registers
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      fragment_limit  <= wsfr_pkg::FragLimitReset;
      max_frame_bytes <= wsfr_pkg::MaxFrameReset;
      phase           <= wsfr_pkg::PH_HDR0;
      fin_flag        <= 1'b0;
      frame_op        <= '0;
      mask_on         <= 1'b0;
      field_cnt       <= '0;
      len_lo          <= '0;
      len_big         <= 1'b0;
      pay_pos         <= '0;
      mask_word       <= '0;
      frag_active     <= 1'b0;
      frag_op         <= '0;
      frag_total      <= '0;
      dead            <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == 1'b0) begin
          fragment_limit <= cfg_data;
        end else begin
          max_frame_bytes <= cfg_data;
        end
      end
      phase       <= phase_next;
      fin_flag    <= fin_flag_next;
      frame_op    <= frame_op_next;
      mask_on     <= mask_on_next;
      field_cnt   <= field_cnt_next;
      len_lo      <= len_lo_next;
      len_big     <= len_big_next;
      pay_pos     <= pay_pos_next;
      mask_word   <= mask_word_next;
      frag_active <= frag_active_next;
      frag_op     <= frag_op_next;
      frag_total  <= frag_total_next;
      dead        <= dead_next;
    end
  end

  // ------------------------------------------------------------------
  // Result queue: up to two words in per byte; while out_ready is high, one word out per cycle
  // ------------------------------------------------------------------
  always_comb begin
    q_cnt_next = q_cnt + QCntW'(step_cnt) - QCntW'(out_fire);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wp  <= '0;
      q_rp  <= '0;
      q_cnt <= '0;
    end else begin
      q_wp  <= q_wp + QPtrW'(step_cnt);
      q_rp  <= q_rp + QPtrW'(out_fire);
      q_cnt <= q_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step_cnt != 2'd0) begin
      q_mem[q_wp] <= step_res[0];
    end
    if (step_cnt == 2'd2) begin
      q_mem[q_wp + QPtrW'(1)] <= step_res[1];
    end
  end

  assign out_valid    = (q_cnt != '0);
  assign kind         = q_mem[q_rp].kind;
  assign has_byte     = q_mem[q_rp].has_byte;
  assign payload_byte = q_mem[q_rp].payload_byte;
  assign is_binary    = q_mem[q_rp].is_binary;
  assign last         = q_mem[q_rp].last;
  assign error_code   = q_mem[q_rp].error_code;

endmodule

// ===== rtl/wsfr_checker.sv =====
// wsfr_checker: port-level assertions for websocket_frame_receiver, plus its bind.
// Depends on assert_macros.svh and wsfr_pkg.
`include "assert_macros.svh"

module wsfr_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] kind,
  input logic       has_byte,
  input logic [7:0] payload_byte,
  input logic       is_binary,
  input logic       last
);

  // held word keeps its kind and byte
  `CHK_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(kind) && $stable(payload_byte), "output word changed while stalled")

  // close and error end the connection: nothing follows them
  `CHK_NEXT(a_final_word, out_valid && out_ready && (kind == wsfr_pkg::KIND_CLOSE || kind == wsfr_pkg::KIND_ERROR), !out_valid, "word after close or error")

  // close and error words carry no byte and no message marks
  `CHK_ALWAYS(a_ctrl_clean, !(out_valid && (kind == wsfr_pkg::KIND_CLOSE || kind == wsfr_pkg::KIND_ERROR)) || (!has_byte && !last && !is_binary), "close or error word carries data marks")

  // an empty word has a zero byte
  `CHK_ALWAYS(a_empty_zero, !(out_valid && !has_byte) || (payload_byte == 8'd0), "byte set on word without data")

endmodule

bind websocket_frame_receiver wsfr_checker u_wsfr_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .kind         (kind),
  .has_byte     (has_byte),
  .payload_byte (payload_byte),
  .is_binary    (is_binary),
  .last         (last)
);

// ===== dv/tb_websocket_frame_receiver.sv =====
// tb_websocket_frame_receiver: self-checking bench for the websocket frame receiver.
// Needs wsfr_pkg and websocket_frame_receiver; a built-in deframer predicts the result words of untyped bytes.
`timescale 1ns / 100ps

module tb_websocket_frame_receiver;
  import wsfr_pkg::*;

  // codes the package does not name
  localparam logic [3:0] OP_CONT = 4'h0;
  localparam logic [3:0] OP_PONG = 4'hA;
  localparam logic [1:0] NO_ERR  = 2'd0;
  localparam logic       REG_FRAG_LIMIT = 1'b0;
  localparam logic       REG_MAX_FRAME  = 1'b1;

  // bench sizing
  localparam int PHASE_BYTES = 200;  // random bytes per register setting
  localparam int HOLD_CYCLES = 160;  // long receiver hold-off
  localparam int DRAIN_CAP   = 20000;

  logic                clk;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  logic [7:0]          rx_byte   = 8'h00;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [1:0]          kind;
  logic                has_byte;
  logic [7:0]          payload_byte;
  logic                is_binary;
  logic                last;
  logic [1:0]          error_code;
  logic                cfg_we    = 1'b0;
  logic                cfg_index = 1'b0;
  logic [LenW-1:0]     cfg_data  = '0;

  websocket_frame_receiver u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .has_byte     (has_byte),
    .payload_byte (payload_byte),
    .is_binary    (is_binary),
    .last         (last),
    .error_code   (error_code),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #(2_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Directed stream: short frames read straight off the protocol.
  // typed=1 rows carry the one word that byte must produce; the rest use the
  // deframer below.
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [7:0] b;
    logic       typed;
    res_t       want;
  } dir_row_t;

  localparam int DIR_ROWS = 27;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    // empty final text frame: one end-of-message word, no byte
    '{8'h81, 1'b0, '0},
    '{8'h00, 1'b1, '{KIND_DATA, 1'b0, 8'h00, 1'b0, 1'b1, NO_ERR}},
    // empty final binary frame
    '{8'h82, 1'b0, '0},
    '{8'h00, 1'b1, '{KIND_DATA, 1'b0, 8'h00, 1'b1, 1'b1, NO_ERR}},
    // empty ping: pong with nothing to echo
    '{8'h89, 1'b0, '0},
    '{8'h00, 1'b1, '{KIND_PING, 1'b0, 8'h00, 1'b0, 1'b1, NO_ERR}},
    // masked text, two bytes at the value extremes
    '{8'h81, 1'b0, '0},
    '{8'h82, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'hA5, 1'b0, '0},
    '{8'h5A, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    // one-byte ping behind a 16-bit length
    '{8'h89, 1'b0, '0},
    '{8'h7E, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h01, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    // binary fragment, pong in between, final continuation
    '{8'h02, 1'b0, '0},
    '{8'h01, 1'b0, '0},
    '{8'h3C, 1'b0, '0},
    '{8'h8A, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h80, 1'b0, '0},
    '{8'h01, 1'b0, '0},
    '{8'hC3, 1'b0, '0}
  };

  // ---------------------------------------------------------------------------
  // Deframer state (bench copy) and register shadows
  // ---------------------------------------------------------------------------
  phase_t          rx_phase;
  logic            rx_fin;
  logic [3:0]      rx_op;
  logic            rx_masked;
  logic [3:0]      rx_cnt;
  logic [63:0]     rx_len;
  logic [LenW-1:0] rx_pos;
  logic [31:0]     rx_key;
  logic            msg_open;
  logic [3:0]      msg_opc;
  logic [LenW-1:0] msg_bytes;
  logic            link_dead;
  logic [LenW-1:0] frag_limit_q;
  logic [LenW-1:0] max_frame_q;

  res_t step_words[$];  // words caused by the byte just taken
  res_t due_words[$];   // words the block still owes, oldest first

  int   mismatches = 0;
  int   sent_bytes = 0;
  int   burst_left = 0;
  bit   hold_req   = 1'b0;

  initial begin
    rx_phase     = PH_HDR0;
    rx_fin       = 1'b0;
    rx_op        = '0;
    rx_masked    = 1'b0;
    rx_cnt       = '0;
    rx_len       = '0;
    rx_pos       = '0;
    rx_key       = '0;
    msg_open     = 1'b0;
    msg_opc      = '0;
    msg_bytes    = '0;
    link_dead    = 1'b0;
    frag_limit_q = FragLimitReset;
    max_frame_q  = MaxFrameReset;
  end

  task automatic flag_mismatch(input string msg);
    if (mismatches < 50) $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  task automatic put_word(input logic [1:0] k, input logic h, input logic [7:0] d,
                          input logic bn, input logic l, input logic [1:0] e);
    res_t w;
    w.kind         = k;
    w.has_byte     = h;
    w.payload_byte = d;
    w.is_binary    = bn;
    w.last         = l;
    w.error_code   = e;
    step_words.push_back(w);
  endtask

  task automatic kill_link(input logic [1:0] code);
    link_dead = 1'b1;
    rx_phase  = PH_HDR0;
    put_word(KIND_ERROR, 1'b0, 8'h00, 1'b0, 1'b0, code);
  endtask

  // a continuation keeps the opcode of the first fragment
  function automatic logic [3:0] carried_op();
    return msg_open ? msg_opc : rx_op;
  endfunction

  function automatic bit counts_toward_msg();
    return (rx_op < OP_CONTROL) && (msg_open || !rx_fin);
  endfunction

  task automatic close_frame(input bit no_payload);
    logic [3:0] m;
    bit         fp;
    rx_phase = PH_HDR0;
    if (rx_op == OP_CLOSE) begin
      link_dead = 1'b1;
      put_word(KIND_CLOSE, 1'b0, 8'h00, 1'b0, 1'b0, NO_ERR);
      return;
    end
    if (rx_op == OP_PING) begin
      if (no_payload) put_word(KIND_PING, 1'b0, 8'h00, 1'b0, 1'b1, NO_ERR);
      return;
    end
    if (rx_op >= OP_CONTROL) return;  // pong, reserved control: dropped
    m  = carried_op();
    fp = counts_toward_msg();
    if (rx_fin && no_payload && (m == OP_TEXT || m == OP_BINARY))
      put_word(KIND_DATA, 1'b0, 8'h00, m == OP_BINARY, 1'b1, NO_ERR);
    if (fp) begin
      if (rx_fin) begin
        msg_open  = 1'b0;
        msg_bytes = '0;
      end else begin
        if (!msg_open) begin
          msg_open = 1'b1;
          msg_opc  = rx_op;
        end
        // fragment limit is judged at the end of each unfinished fragment
        if (msg_bytes >= frag_limit_q) kill_link(ERR_FRAG_LIM);
      end
    end
  endtask

  task automatic open_payload();
    rx_pos = '0;
    if (rx_len == 64'd0) close_frame(1'b1);
    else rx_phase = PH_DATA;
  endtask

  task automatic length_done();
    logic [63:0] hdr_len;
    hdr_len = (rx_phase == PH_EXT16) ? 64'(HDR_EXT16) :
              (rx_phase == PH_EXT64) ? 64'(HDR_EXT64) : 64'(HDR_BASE);
    if (rx_masked) hdr_len = hdr_len + 64'(HDR_KEY);
    // whole frame, header included, must fit
    if (64'(max_frame_q) < hdr_len || rx_len > 64'(max_frame_q) - hdr_len) begin
      kill_link(ERR_TOO_LARGE);
      return;
    end
    rx_cnt = '0;
    if (rx_masked) rx_phase = PH_MASK;
    else open_payload();
  endtask

  task automatic take_payload(input logic [7:0] raw);
    logic [7:0] d;
    logic [1:0] k;
    logic [3:0] m;
    bit         at_end;
    d = raw;
    k = rx_pos[1:0];
    if (rx_masked) d = d ^ rx_key[31 - 8 * k -: 8];
    rx_pos = rx_pos + 1'b1;
    at_end = (64'(rx_pos) >= rx_len);
    if (rx_op == OP_PING) begin
      put_word(KIND_PING, 1'b1, d, 1'b0, at_end, NO_ERR);
    end else if (rx_op < OP_CONTROL) begin
      m = carried_op();
      if (counts_toward_msg() && msg_bytes != LenSat) msg_bytes = msg_bytes + 1'b1;
      if (m == OP_TEXT || m == OP_BINARY)
        put_word(KIND_DATA, 1'b1, d, m == OP_BINARY, at_end && rx_fin, NO_ERR);
    end
    if (at_end) close_frame(1'b0);
  endtask

  // advance the deframer by one received byte; results land in step_words
  task automatic deframe_byte(input logic [7:0] b);
    step_words.delete();
    if (link_dead) return;
    case (rx_phase)
      PH_HDR0: begin
        if (b[6]) kill_link(ERR_RSV1);
        else if (b[5:4] != 2'b00) kill_link(ERR_RSV23);
        else begin
          rx_fin   = b[7];
          rx_op    = b[3:0];
          rx_phase = PH_HDR1;
        end
      end
      PH_HDR1: begin
        rx_masked = b[7];
        rx_key    = '0;
        rx_pos    = '0;
        rx_cnt    = '0;
        rx_len    = '0;
        if (b[6:0] == LEN_EXT16) rx_phase = PH_EXT16;
        else if (b[6:0] == LEN_EXT64) rx_phase = PH_EXT64;
        else begin
          rx_len = 64'(b[6:0]);
          length_done();
        end
      end
      PH_EXT16, PH_EXT64: begin
        rx_len = {rx_len[55:0], b};
        rx_cnt = rx_cnt + 1'b1;
        if (rx_cnt == ((rx_phase == PH_EXT16) ? CNT_EXT16 : CNT_EXT64)) length_done();
      end
      PH_MASK: begin
        rx_key = {rx_key[23:0], b};
        rx_cnt = rx_cnt + 1'b1;
        if (rx_cnt >= CNT_KEY) open_payload();
      end
      PH_DATA: begin
        take_payload(b);
      end
      default: begin
        rx_phase = PH_HDR0;
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Sender side. All driver tasks run just after a rising edge.
  // ---------------------------------------------------------------------------
  task automatic offer_byte(input logic [7:0] b, input bit typed, input res_t want);
    // bursts of random length; now and then a long burst with no gaps
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? 300 : $urandom_range(1, 20);
    end
    burst_left--;
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_bytes++;
    deframe_byte(b);
    if (typed) due_words.push_back(want);
    else foreach (step_words[i]) due_words.push_back(step_words[i]);
  endtask

  // register write once the block has settled; sender stays quiet meanwhile
  task automatic write_reg(input logic idx, input logic [LenW-1:0] val);
    in_valid <= 1'b0;
    while (due_words.size() != 0) @(posedge clk);
    // bytes that produce no word may still be in flight
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_FRAG_LIMIT) frag_limit_q = val;
    else max_frame_q = val;
  endtask

  task automatic apply_setting(input int frag_lim, input int max_bytes);
    write_reg(REG_FRAG_LIMIT, LenW'(frag_lim));
    write_reg(REG_MAX_FRAME, LenW'(max_bytes));
  endtask

  // enc: 0 seven-bit length, 1 sixteen-bit, 2 sixty-four-bit
  task automatic send_frame(input bit fin, input logic [3:0] op, input bit masked,
                            input int len, input int enc);
    logic [63:0] l64;
    logic [7:0]  b;
    int          i;
    l64 = 64'(len);
    offer_byte({fin, 3'b000, op}, 1'b0, '0);
    case (enc)
      0: offer_byte({masked, 7'(len)}, 1'b0, '0);
      1: begin
        offer_byte({masked, LEN_EXT16}, 1'b0, '0);
        for (i = 1; i >= 0; i--) offer_byte(l64[8 * i +: 8], 1'b0, '0);
      end
      default: begin
        offer_byte({masked, LEN_EXT64}, 1'b0, '0);
        for (i = 7; i >= 0; i--) offer_byte(l64[8 * i +: 8], 1'b0, '0);
      end
    endcase
    if (masked) repeat (4) offer_byte(8'($urandom), 1'b0, '0);
    for (i = 0; i < len; i++) begin
      case ($urandom_range(0, 15))
        0:       b = 8'h00;
        1:       b = 8'hFF;
        default: b = 8'($urandom);
      endcase
      offer_byte(b, 1'b0, '0);
    end
  endtask

  // one well-formed frame that keeps the connection open
  task automatic random_frame();
    int         pick, len, enc, hdr, room, r;
    bit         fin, masked;
    logic [3:0] op;
    pick = $urandom_range(0, 99);
    fin  = ($urandom_range(0, 2) != 0);
    if (pick < 55) begin
      // message data: usually a continuation while a message is open, else a new start
      if (msg_open && pick >= 5) op = OP_CONT;
      else op = $urandom_range(0, 1) ? OP_TEXT : OP_BINARY;
    end else if (pick < 70) begin
      op  = OP_PING;
      fin = ($urandom_range(0, 7) != 0);
    end else if (pick < 82) begin
      op = 4'($urandom_range(int'(OP_PONG), 15));
    end else begin
      // continuation or reserved data opcode: silent unless a message is open
      op = 4'($urandom_range(0, 5));
      if (op != OP_CONT) op = op + 4'd2;
    end
    r = $urandom_range(0, 99);
    if (r < 65) len = $urandom_range(0, 12);
    else if (r < 90) len = $urandom_range(13, 125);
    else len = $urandom_range(126, 300);
    masked = $urandom_range(0, 1);
    if (len > 125) enc = ($urandom_range(0, 4) == 0) ? 2 : 1;
    else begin
      r   = $urandom_range(0, 9);
      enc = (r < 7) ? 0 : (r < 9) ? 1 : 2;
    end
    hdr  = (enc == 1) ? int'(HDR_EXT16) : (enc == 2) ? int'(HDR_EXT64) : int'(HDR_BASE);
    if (masked) hdr = hdr + int'(HDR_KEY);
    room = int'(max_frame_q) - hdr;
    if (len > room) len = room;
    // an unfinished fragment must stay under the fragment limit
    if (op < OP_CONTROL && !fin && int'(msg_bytes) + len >= int'(frag_limit_q)) begin
      if (int'(msg_bytes) < int'(frag_limit_q)) len = int'(frag_limit_q) - 1 - int'(msg_bytes);
      else fin = 1'b1;
    end
    send_frame(fin, op, masked, len, enc);
  endtask

  // final act: one of the ways the connection ends, then bytes that must be ignored
  task automatic end_connection();
    logic [7:0]  b;
    logic [63:0] l64;
    int          i, lim;
    case ($urandom_range(0, 4))
      0: send_frame(1'b1, OP_CLOSE, $urandom_range(0, 1), $urandom_range(0, 6), 0);
      1: begin
        b    = 8'($urandom);
        b[6] = 1'b1;
        offer_byte(b, 1'b0, '0);
      end
      2: begin
        b      = 8'($urandom);
        b[6]   = 1'b0;
        b[5:4] = 2'($urandom_range(1, 3));
        offer_byte(b, 1'b0, '0);
      end
      3: begin
        lim = $urandom_range(1, 8);
        apply_setting(lim, 1048576);
        send_frame(1'b0, msg_open ? OP_CONT : OP_TEXT, $urandom_range(0, 1),
                   lim + $urandom_range(0, 3), 0);
      end
      default: begin
        // length beyond the frame limit, sometimes absurdly so
        if ($urandom_range(0, 1)) l64 = {32'hFFFF_FFFF, 32'($urandom)};
        else l64 = 64'(max_frame_q) + 64'($urandom_range(0, 50));
        offer_byte({1'b1, 3'b000, OP_BINARY}, 1'b0, '0);
        offer_byte({1'($urandom_range(0, 1)), LEN_EXT64}, 1'b0, '0);
        for (i = 7; i >= 0; i--) offer_byte(l64[8 * i +: 8], 1'b0, '0);
      end
    endcase
    repeat ($urandom_range(8, 20)) offer_byte(8'($urandom), 1'b0, '0);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: stall pattern, one long hold-off, and the word check
  // ---------------------------------------------------------------------------
  task automatic check_word();
    res_t want;
    if (due_words.size() == 0) begin
      flag_mismatch("result word with nothing expected");
      return;
    end
    want = due_words.pop_front();
    if (kind !== want.kind)
      flag_mismatch($sformatf("kind got %0d want %0d", kind, want.kind));
    if (has_byte !== want.has_byte)
      flag_mismatch($sformatf("has_byte got %0d want %0d", has_byte, want.has_byte));
    if (payload_byte !== want.payload_byte)
      flag_mismatch($sformatf("payload_byte got %h want %h", payload_byte, want.payload_byte));
    if (is_binary !== want.is_binary)
      flag_mismatch($sformatf("is_binary got %0d want %0d", is_binary, want.is_binary));
    if (last !== want.last)
      flag_mismatch($sformatf("last got %0d want %0d", last, want.last));
    if (error_code !== want.error_code)
      flag_mismatch($sformatf("error_code got %0d want %0d", error_code, want.error_code));
  endtask

  initial begin : receiver
    logic [15:0] pat;
    int          mode, hold_left, tick;
    pat       = 16'hFFFF;
    mode      = 0;
    hold_left = 0;
    tick      = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) check_word();
      tick++;
      // redraw of the stall mode: none, rotating pattern, or biased random draws
      if (tick % 64 == 0) begin
        mode = $urandom_range(0, 2);
        pat  = 16'($urandom);
      end
      if (hold_req && hold_left == 0) hold_left = HOLD_CYCLES;
      if (hold_left > 0) begin
        // long hold-off: the result queue fills and in_ready must drop
        hold_left--;
        if (hold_left == 0) hold_req = 1'b0;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          0: out_ready <= 1'b1;
          1: begin
            out_ready <= pat[0];
            pat = {pat[0], pat[15:1]};
          end
          default: out_ready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : driver
    int p, f_lim, m_max, phase_start, waited;
    while (rst) @(posedge clk);

    // directed frames run on the reset register values
    for (int i = 0; i < DIR_ROWS; i++)
      offer_byte(DIRECTED[i].b, DIRECTED[i].typed, DIRECTED[i].want);

    // random traffic under several register settings, extremes first
    for (p = 0; p < 6; p++) begin
      case (p)
        0: begin f_lim = 1;       m_max = 14;      end
        1: begin f_lim = 1048576; m_max = 1048576; end
        2: begin f_lim = $urandom_range(1, 64);      m_max = $urandom_range(14, 400);     end
        3: begin f_lim = $urandom_range(1, 1048576); m_max = $urandom_range(14, 1048576); end
        4: begin f_lim = 3;       m_max = 40;      end
        default: begin f_lim = int'(FragLimitReset); m_max = int'(MaxFrameReset); end
      endcase
      apply_setting(f_lim, m_max);
      if (p == 1) begin
        // a long text frame lands on the receiver hold-off
        hold_req = 1'b1;
        send_frame(1'b1, OP_TEXT, 1'b1, 40, 0);
      end
      phase_start = sent_bytes;
      while (sent_bytes - phase_start < PHASE_BYTES) random_frame();
    end

    end_connection();
    in_valid <= 1'b0;

    waited = 0;
    while (due_words.size() != 0 && waited < DRAIN_CAP) begin
      @(posedge clk);
      waited++;
    end
    if (due_words.size() != 0)
      flag_mismatch($sformatf("%0d result words never arrived", due_words.size()));
    repeat (8) @(posedge clk);

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/wsfr_pkg.sv
rtl/websocket_frame_receiver.sv
rtl/wsfr_checker.sv
dv/tb_websocket_frame_receiver.sv
